[hw/rtl/saw_pkg.sv]
// Shared types, constants and configuration layout for the stop-and-wait sender.
package saw_pkg;

  // Default geometry of the packet ring
  localparam int unsigned QueueDepthDef  = 8;
  localparam int unsigned PacketBytesDef = 9;

  // Frame layout: three header bytes, then the packet
  localparam int unsigned HdrBytes = 3;

  // Frame command queue between classifier and emitter
  localparam int unsigned CmdqDepth = 2;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_PKT_BYTE = 2'd0,
    CMD_RX_CODE  = 2'd1,
    CMD_TICK     = 2'd2
  } saw_cmd_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEST_ADDR_HIGH = 3'd0,
    CFG_DEST_ADDR_LOW  = 3'd1,
    CFG_DEST_CHANNEL   = 3'd2,
    CFG_ACK_CODE       = 3'd3,
    CFG_NACK_CODE      = 3'd4,
    CFG_TIMEOUT_TICKS  = 3'd5
  } saw_cfg_idx_e;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0]  dest_addr_high;
    logic [7:0]  dest_addr_low;
    logic [7:0]  dest_channel;
    logic [7:0]  ack_code;
    logic [7:0]  nack_code;
    logic [15:0] timeout_ticks;
  } saw_cfg_t;

  // Reset values of the configuration registers
  localparam saw_cfg_t CfgReset = '{
    dest_addr_high: 8'h07,
    dest_addr_low:  8'h60,
    dest_channel:   8'h1F,
    ack_code:       8'h01,
    nack_code:      8'h02,
    timeout_ticks:  16'd600
  };

endpackage

[hw/rtl/saw_fifo.sv]
// Short frame command queue between the classifier and the frame emitter.
module saw_fifo import saw_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = CmdqDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = entry_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/saw_front.sv]
// Classifier: takes input transactions, keeps the ring and ARQ state, queues frames.
module saw_front import saw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef,
  parameter int unsigned PACKET_BYTES = PacketBytesDef,
  parameter int unsigned AddrW        = $clog2(QUEUE_DEPTH * PACKET_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  saw_cfg_t         cfg_i,
  // Input channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic [7:0]       data_byte_i,
  // Store write port
  output logic             mem_we_o,
  output logic [AddrW-1:0] mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  // Frame command queue
  output logic             fq_push_o,
  output logic [AddrW:0]   fq_data_o,
  input  logic             fq_full_i,
  input  logic             back_busy_i
);

  localparam int unsigned StoreBytes = QUEUE_DEPTH * PACKET_BYTES;
  localparam int unsigned FillW      = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int unsigned HeldW      = $clog2(QUEUE_DEPTH + 1);

  logic [AddrW-1:0] rd_base_q, rd_base_d, wr_base_q, wr_base_d;
  logic [HeldW-1:0] held_q, held_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             dropping_q, dropping_d;
  logic             await_q, await_d;
  logic [15:0]      elapsed_q, elapsed_d;

  logic             accept;
  logic             drop_now;
  logic             fq_resend;
  logic [15:0]      elapsed_inc;
  logic [AddrW-1:0] rd_base_next, wr_base_next;

  // Packet bytes wait while a frame may still read the store
  assign in_ready_o = !fq_full_i && ((cmd_i != CMD_PKT_BYTE) || !back_busy_i);
  assign accept     = in_valid_i && in_ready_o;

  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

  // Ring base addresses advance one packet, wrapping at the end of the store
  assign rd_base_next = (rd_base_q == AddrW'(StoreBytes - PACKET_BYTES)) ? '0
                      : rd_base_q + AddrW'(PACKET_BYTES);
  assign wr_base_next = (wr_base_q == AddrW'(StoreBytes - PACKET_BYTES)) ? '0
                      : wr_base_q + AddrW'(PACKET_BYTES);

  // Drop decision is taken at a packet's first byte
  assign drop_now = (fill_q == '0) ? (held_q == HeldW'(QUEUE_DEPTH)) : dropping_q;

  assign mem_waddr_o = wr_base_q + AddrW'(fill_q);
  assign mem_wdata_o = data_byte_i;
  assign fq_data_o   = {fq_resend, rd_base_q};

  // Transaction decode
  always_comb begin
    rd_base_d  = rd_base_q;
    wr_base_d  = wr_base_q;
    held_d     = held_q;
    fill_d     = fill_q;
    dropping_d = dropping_q;
    await_d    = await_q;
    elapsed_d  = elapsed_q;
    mem_we_o   = 1'b0;
    fq_push_o  = 1'b0;
    fq_resend  = 1'b0;
    if (accept) begin
      case (cmd_i)
        CMD_PKT_BYTE: begin
          mem_we_o = !drop_now;
          if (fill_q == FillW'(PACKET_BYTES - 1)) begin
            fill_d     = '0;
            dropping_d = 1'b0;
            if (!drop_now) begin
              wr_base_d = wr_base_next;
              held_d    = held_q + 1'b1;
            end
          end else begin
            fill_d     = fill_q + 1'b1;
            dropping_d = drop_now;
          end
        end
        CMD_RX_CODE: begin
          if (data_byte_i == cfg_i.ack_code) begin
            if (held_q != '0) begin
              rd_base_d = rd_base_next;
              held_d    = held_q - 1'b1;
            end
            await_d = 1'b0;
          end else if (data_byte_i == cfg_i.nack_code) begin
            if (held_q == '0) begin
              await_d = 1'b0;
            end else begin
              fq_push_o = 1'b1;
              fq_resend = 1'b1;
              await_d   = 1'b1;
              elapsed_d = '0;
            end
          end
        end
        CMD_TICK: begin
          elapsed_d = elapsed_inc;
          if (!await_q && held_q != '0) begin
            fq_push_o = 1'b1;
            await_d   = 1'b1;
            elapsed_d = '0;
          end else if (await_q) begin
            if (held_q == '0) begin
              await_d = 1'b0;
            end else if (elapsed_inc > cfg_i.timeout_ticks) begin
              fq_push_o = 1'b1;
              fq_resend = 1'b1;
              elapsed_d = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_base_q  <= '0;
      wr_base_q  <= '0;
      held_q     <= '0;
      fill_q     <= '0;
      dropping_q <= 1'b0;
      await_q    <= 1'b0;
      elapsed_q  <= '0;
    end else begin
      rd_base_q  <= rd_base_d;
      wr_base_q  <= wr_base_d;
      held_q     <= held_d;
      fill_q     <= fill_d;
      dropping_q <= dropping_d;
      await_q    <= await_d;
      elapsed_q  <= elapsed_d;
    end
  end

  // Ring never holds more packets than slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(QUEUE_DEPTH))
    else $error("ring occupancy above depth");

  // A frame is only queued for a non-empty ring, and the wait is armed afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_push_o |-> (held_q != '0) ##1 await_q)
    else $error("frame queued without packet or wait not armed");

  // No store write while the emitter may still read it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> !back_busy_i)
    else $error("store written during frame emission");

endmodule

[hw/rtl/saw_back.sv]
// Frame emitter: packet store, byte sequencer, read stage and output register.
module saw_back import saw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef,
  parameter int unsigned PACKET_BYTES = PacketBytesDef,
  parameter int unsigned AddrW        = $clog2(QUEUE_DEPTH * PACKET_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  saw_cfg_t         cfg_i,
  // Store write port
  input  logic             mem_we_i,
  input  logic [AddrW-1:0] mem_waddr_i,
  input  logic [7:0]       mem_wdata_i,
  // Frame command queue
  input  logic             fq_valid_i,
  input  logic [AddrW:0]   fq_data_i,
  output logic             fq_pop_o,
  output logic             busy_o,
  // Output channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       frame_byte_o,
  output logic             frame_last_o,
  output logic             is_resend_o
);

  localparam int unsigned StoreBytes = QUEUE_DEPTH * PACKET_BYTES;
  localparam int unsigned FrameBytes = HdrBytes + PACKET_BYTES;
  localparam int unsigned IdxW       = $clog2(FrameBytes);

  logic [7:0]       mem_q [StoreBytes];

  // Sequencer
  logic             busy_q;
  logic [IdxW-1:0]  idx_q;
  logic [AddrW-1:0] ptr_q;
  logic             resend_q;

  // Read stage
  logic             a_valid_q, a_pkt_q, a_last_q, a_resend_q;
  logic [7:0]       a_hdr_q, rd_data_q;

  logic             a_adv, b_adv, issue, rd_en, is_pkt;
  logic [7:0]       hdr_byte;

  assign b_adv    = !out_valid_o || out_ready_i;
  assign a_adv    = !a_valid_q || b_adv;
  assign issue    = busy_q && a_adv;
  assign is_pkt   = (idx_q >= IdxW'(HdrBytes));
  assign rd_en    = issue && is_pkt;
  assign fq_pop_o = !busy_q && fq_valid_i;
  assign busy_o   = busy_q || fq_valid_i;

  // Header byte select
  always_comb begin
    case (idx_q)
      IdxW'(0): hdr_byte = cfg_i.dest_addr_high;
      IdxW'(1): hdr_byte = cfg_i.dest_addr_low;
      default:  hdr_byte = cfg_i.dest_channel;
    endcase
  end

  // Byte sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      idx_q    <= '0;
      ptr_q    <= '0;
      resend_q <= 1'b0;
    end else if (fq_pop_o) begin
      busy_q   <= 1'b1;
      idx_q    <= '0;
      ptr_q    <= fq_data_i[AddrW-1:0];
      resend_q <= fq_data_i[AddrW];
    end else if (issue) begin
      if (idx_q == IdxW'(FrameBytes - 1)) begin
        busy_q <= 1'b0;
      end
      idx_q <= idx_q + 1'b1;
      if (is_pkt) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  // Packet store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem_q[mem_waddr_i] <= mem_wdata_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[ptr_q];
    end
  end

  // Read stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_adv) begin
      a_valid_q <= busy_q;
    end
  end

  // Read stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      a_pkt_q    <= is_pkt;
      a_hdr_q    <= hdr_byte;
      a_last_q   <= (idx_q == IdxW'(FrameBytes - 1));
      a_resend_q <= resend_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (b_adv) begin
      out_valid_o <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && a_valid_q) begin
      frame_byte_o <= a_pkt_q ? rd_data_q : a_hdr_q;
      frame_last_o <= a_last_q;
      is_resend_o  <= a_resend_q;
    end
  end

  // Store reads stay inside the packet bytes of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> busy_q && (idx_q >= IdxW'(HdrBytes)))
    else $error("store read outside packet bytes");

  // A held read stage keeps its store data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !a_adv) |=> $stable(rd_data_q))
    else $error("read data lost under stall");

  // Sequencer goes idle only after issuing the last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(idx_q == IdxW'(FrameBytes - 1)))
    else $error("frame ended early");

endmodule

[hw/rtl/stop_and_wait_packet_sender.sv]
// Top level: configuration registers, classifier, frame queue and emitter.
// Non-frame transactions (packet bytes, ignored codes) are taken one per cycle while
// in_ready_o is high. A frame of 3 + PACKET_BYTES bytes goes from the sending
// transaction through the frame queue, sequencer, read stage and output register,
// and leaves one byte per cycle while out_ready_i is high.
// Packet bytes stall while a frame is queued or being read from the store.
// Reset (async, active low) empties ring and queues and reloads configuration.
module stop_and_wait_packet_sender import saw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef,
  parameter int unsigned PACKET_BYTES = PacketBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          cmd_i,
  input  logic [7:0]          data_byte_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          frame_byte_o,
  output logic                frame_last_o,
  output logic                is_resend_o
);

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH * PACKET_BYTES);

  saw_cfg_t         cfg_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             fq_push, fq_full, fq_valid, fq_pop, back_busy;
  logic [AddrW:0]   fq_push_data, fq_pop_data;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEST_ADDR_HIGH: cfg_q.dest_addr_high <= cfg_data_i[7:0];
        CFG_DEST_ADDR_LOW:  cfg_q.dest_addr_low  <= cfg_data_i[7:0];
        CFG_DEST_CHANNEL:   cfg_q.dest_channel   <= cfg_data_i[7:0];
        CFG_ACK_CODE:       cfg_q.ack_code       <= cfg_data_i[7:0];
        CFG_NACK_CODE:      cfg_q.nack_code      <= cfg_data_i[7:0];
        CFG_TIMEOUT_TICKS:  cfg_q.timeout_ticks  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  saw_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PACKET_BYTES(PACKET_BYTES),
    .AddrW       (AddrW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .data_byte_i(data_byte_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .fq_push_o  (fq_push),
    .fq_data_o  (fq_push_data),
    .fq_full_i  (fq_full),
    .back_busy_i(back_busy)
  );

  saw_fifo #(
    .Width(AddrW + 1),
    .Depth(CmdqDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (fq_push),
    .push_data_i(fq_push_data),
    .full_o     (fq_full),
    .pop_valid_o(fq_valid),
    .pop_i      (fq_pop),
    .pop_data_o (fq_pop_data)
  );

  saw_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PACKET_BYTES(PACKET_BYTES),
    .AddrW       (AddrW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .mem_we_i    (mem_we),
    .mem_waddr_i (mem_waddr),
    .mem_wdata_i (mem_wdata),
    .fq_valid_i  (fq_valid),
    .fq_data_i   (fq_pop_data),
    .fq_pop_o    (fq_pop),
    .busy_o      (back_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_byte_o(frame_byte_o),
    .frame_last_o(frame_last_o),
    .is_resend_o (is_resend_o)
  );

endmodule
